// File: design/pbtr_pkg.sv
`timescale 1ns / 1ps
package pbtr_pkg;

  localparam logic [7:0] START_BYTE   = 8'h78;
  localparam logic [7:0] LINE_INVERT  = 8'hFF;
  localparam logic [8:0] LENGTH_LIMIT = 9'd32;
  localparam logic [15:0] SUM_BIAS    = 16'd254;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_GAP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_LENGTH   = 2'd2
  } frame_status_e;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_LOAD = 3'b100
  } back_state_e;

  // One finished telegram handed from the receive side to the drain side.
  typedef struct packed {
    frame_status_e status;
    logic [5:0]    last_idx;
    logic          bank;
  } desc_t;

  typedef struct packed {
    logic free;
    logic bank;
  } bank_free_t;

endpackage

// File: design/pbtr_if.sv
`timescale 1ns / 1ps
interface pbtr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] line_byte;

  modport source (output valid, output command, output line_byte, input ready);
  modport sink (input valid, input command, input line_byte, output ready);
endinterface

interface pbtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic [1:0] frame_status;
  logic       last;

  modport source (output valid, output frame_byte, output byte_index, output frame_status,
                  output last, input ready);
  modport sink (input valid, input frame_byte, input byte_index, input frame_status,
                input last, output ready);
endinterface

// File: design/pbtr_ram.sv
`timescale 1ns / 1ps
module pbtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: design/pbtr_queue.sv
`timescale 1ns / 1ps
module pbtr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pbtr_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output pbtr_pkg::desc_t desc_o,
  output logic            empty_o
);
  import pbtr_pkg::*;

  desc_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign desc_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// File: design/pbtr_front.sv
`timescale 1ns / 1ps
module pbtr_front #(
  parameter int FRAME_BYTES_MAX = 33,
  parameter int LENGTH_POSITION = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pbtr_in_if.sink                             in_i,
  output logic                                push_o,
  output pbtr_pkg::desc_t                     desc_o,
  input  logic                                full_i,
  input  pbtr_pkg::bank_free_t                free_i,
  output logic                                wr_en_o,
  output logic [$clog2(FRAME_BYTES_MAX):0]    wr_addr_o,
  output logic [7:0]                          wr_data_o
);
  import pbtr_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES_MAX + 1);
  localparam int AW = $clog2(FRAME_BYTES_MAX);
  localparam logic [8:0] LP9  = 9'(LENGTH_POSITION);
  localparam logic [8:0] MAX9 = 9'(FRAME_BYTES_MAX);

  logic          in_frame_q, in_frame_d;
  logic [CW-1:0] count_q, count_d;
  logic          bank_q, bank_d;
  logic [1:0]    busy_q, busy_d;
  logic [7:0]    len_q, len_d;
  logic [15:0]   acc_q, acc_d;
  logic [7:0]    hist1_q, hist1_d;
  logic [7:0]    hist2_q, hist2_d;

  logic          accept;
  logic [7:0]    b;
  logic          store;
  logic [CW-1:0] k;
  logic [8:0]    k9, n9, len9;
  logic [7:0]    len;
  logic [15:0]   acc_new;
  logic          frame_end;
  frame_status_e outcome;

  assign in_i.ready = !full_i && !busy_q[bank_q];
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.line_byte ^ LINE_INVERT;
  assign store      = (in_i.command == CMD_BYTE) && (in_frame_q || (b == START_BYTE));
  assign k          = in_frame_q ? count_q : '0;
  assign k9         = 9'(k);
  assign n9         = k9 + 9'd1;
  assign len        = (k9 == LP9) ? b : len_q;
  assign len9       = {1'b0, len};

  always_comb begin
    acc_new = in_frame_q ? acc_q : 16'd0;
    if (k9 >= 9'd2) begin
      acc_new = acc_new + {8'd0, hist2_q};
    end
    if (k9 == LP9) begin
      acc_new = acc_new + SUM_BIAS - {b, 8'd0} + {8'd0, b};
    end
  end

  assign frame_end = ((n9 > LP9) && ((len9 > LENGTH_LIMIT) || (n9 >= len9 + 9'd1)))
                     || (n9 >= MAX9);

  always_comb begin
    if (n9 <= LP9 || n9 != len9 + 9'd1 || len9 < 9'd1) begin
      outcome = STATUS_LENGTH;
    end else if (acc_new != {hist1_q, b}) begin
      outcome = STATUS_CHECKSUM;
    end else begin
      outcome = STATUS_OK;
    end
  end

  always_comb begin
    in_frame_d      = in_frame_q;
    count_d         = count_q;
    bank_d          = bank_q;
    busy_d          = busy_q;
    len_d           = len_q;
    acc_d           = acc_q;
    hist1_d         = hist1_q;
    hist2_d         = hist2_q;
    push_o          = 1'b0;
    desc_o.status   = STATUS_LENGTH;
    desc_o.last_idx = 6'(k);
    desc_o.bank     = bank_q;
    wr_en_o         = 1'b0;
    if (free_i.free) begin
      busy_d[free_i.bank] = 1'b0;
    end
    if (accept) begin
      if (in_i.command == CMD_GAP) begin
        if (in_frame_q) begin
          push_o     = 1'b1;
          in_frame_d = 1'b0;
          count_d    = '0;
        end
      end else if (store) begin
        wr_en_o = 1'b1;
        len_d   = len;
        acc_d   = acc_new;
        hist1_d = b;
        hist2_d = hist1_q;
        if (frame_end) begin
          push_o        = 1'b1;
          desc_o.status = outcome;
          in_frame_d    = 1'b0;
          count_d       = '0;
          if (outcome == STATUS_OK) begin
            busy_d[bank_q] = 1'b1;
            bank_d         = !bank_q;
          end
        end else begin
          in_frame_d = 1'b1;
          count_d    = CW'(n9);
        end
      end
    end
  end

  assign wr_addr_o = {bank_q, k[AW-1:0]};
  assign wr_data_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      bank_q     <= 1'b0;
      busy_q     <= 2'b00;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    acc_q   <= acc_d;
    hist1_q <= hist1_d;
    hist2_q <= hist2_d;
  end

endmodule

// File: design/pbtr_back.sv
`timescale 1ns / 1ps
module pbtr_back #(
  parameter int FRAME_BYTES_MAX = 33
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pbtr_pkg::desc_t                   desc_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output pbtr_pkg::bank_free_t              free_o,
  output logic                              rd_en_o,
  output logic [$clog2(FRAME_BYTES_MAX):0]  rd_addr_o,
  input  logic [7:0]                        rd_data_i,
  pbtr_out_if.source                        out_o
);
  import pbtr_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES_MAX);

  back_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [5:0]  idx_q, idx_d;
  logic [5:0]  last_idx_q, last_idx_d;
  logic        bank_q, bank_d;
  logic        load;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [5:0]  out_idx_q, out_idx_d;
  logic [1:0]  out_status_q, out_status_d;
  logic        out_last_q, out_last_d;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    idx_d        = idx_q;
    last_idx_d   = last_idx_q;
    bank_d       = bank_q;
    load         = 1'b0;
    out_byte_d   = out_byte_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    free_o.free  = 1'b0;
    free_o.bank  = bank_q;
    rd_en_o      = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i && !out_valid_q) begin
          pop_o = 1'b1;
          if (desc_i.status != STATUS_OK) begin
            load         = 1'b1;
            out_byte_d   = 8'd0;
            out_idx_d    = 6'd0;
            out_status_d = desc_i.status;
            out_last_d   = 1'b1;
          end else begin
            idx_d      = 6'd0;
            last_idx_d = desc_i.last_idx;
            bank_d     = desc_i.bank;
            state_d    = B_READ;
          end
        end
      end
      B_READ: begin
        rd_en_o = 1'b1;
        state_d = B_LOAD;
      end
      B_LOAD: begin
        if (!out_valid_q) begin
          load         = 1'b1;
          out_byte_d   = rd_data_i;
          out_idx_d    = idx_q;
          out_status_d = STATUS_OK;
          out_last_d   = (idx_q == last_idx_q);
          if (idx_q == last_idx_q) begin
            free_o.free = 1'b1;
            state_d     = B_IDLE;
          end else begin
            idx_d   = idx_q + 6'd1;
            state_d = B_READ;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  assign rd_addr_o = {bank_q, idx_q[AW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    last_idx_q   <= last_idx_d;
    bank_q       <= bank_d;
    out_byte_q   <= out_byte_d;
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_byte   = out_byte_q;
  assign out_o.byte_index   = out_idx_q;
  assign out_o.frame_status = out_status_q;
  assign out_o.last         = out_last_q;

endmodule

// File: design/process_bus_telegram_receiver.sv
`timescale 1ns / 1ps
// Process bus telegram receiver. Each transaction on in_i is either a raw
// (bit-inverted) line byte or an inter-byte gap event. Line bytes are taken in
// one cycle each and written straight into one of two frame buffer banks;
// the length check and the 16-bit sum are kept running, so the frame verdict
// is known on the cycle its final byte is taken. A good telegram is then
// played out of the frame buffer byte by byte (a RAM read state overlaps the
// hand-off of the previous byte, then a load state fills the output register
// once it is free) with status ok and last on its final byte; checksum and
// length failures give a single status transaction. The two banks let the
// next telegram be received while the previous one drains; in_i stalls only
// when both banks still hold undelivered telegrams or the two-entry verdict
// queue is full. No clearing pass is needed after reset.
module process_bus_telegram_receiver #(
  parameter int FRAME_BYTES_MAX = 33,
  parameter int LENGTH_POSITION = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbtr_in_if.sink    in_i,
  pbtr_out_if.source out_o
);
  import pbtr_pkg::*;

  localparam int AW    = $clog2(FRAME_BYTES_MAX);
  localparam int DEPTH = 2 * (1 << AW);

  logic            push, full, pop, empty;
  desc_t           push_desc, head_desc;
  bank_free_t      bank_free;
  logic            wr_en, rd_en;
  logic [AW:0]     wr_addr, rd_addr;
  logic [7:0]      wr_data, rd_data;

  pbtr_front #(
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX),
    .LENGTH_POSITION (LENGTH_POSITION)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .push_o    (push),
    .desc_o    (push_desc),
    .full_i    (full),
    .free_i    (bank_free),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  pbtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .desc_o  (head_desc),
    .empty_o (empty)
  );

  pbtr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pbtr_back #(
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .desc_i    (head_desc),
    .empty_i   (empty),
    .pop_o     (pop),
    .free_o    (bank_free),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .out_o     (out_o)
  );

endmodule

// File: tb/process_bus_telegram_receiver_checker.sv
`timescale 1ns / 1ps
module process_bus_telegram_receiver_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pbtr_in_if   in_i,
  pbtr_out_if  out_i,
  output int   error_count_o,
  output int   pending_o
);
  import pbtr_pkg::*;

  localparam int FRAME_BYTES = 33;
  localparam int LENGTH_POS  = 1;

  typedef struct packed {
    logic [7:0]    frame_byte;
    logic [5:0]    byte_index;
    frame_status_e frame_status;
    logic          last;
  } telegram_result_t;

  telegram_result_t expected_results_q[$];
  telegram_result_t oldest_result;
  logic [7:0]       frame_mem [FRAME_BYTES];
  int               stored_count;
  logic             in_frame;
  int               error_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void push_result(logic [7:0] value, int idx, frame_status_e status,
                                      logic last_mark);
    telegram_result_t r;
    r.frame_byte   = value;
    r.byte_index   = idx[5:0];
    r.frame_status = status;
    r.last         = last_mark;
    expected_results_q.push_back(r);
  endfunction

  function automatic void push_status(frame_status_e status);
    push_result(8'h00, 0, status, 1'b1);
    in_frame     = 1'b0;
    stored_count = 0;
  endfunction

  // Telegram decoder: one line transaction in, zero or more results queued.
  task automatic predict_line_item(input logic command, input logic [7:0] raw);
    logic [7:0]  value;
    logic [15:0] sum;
    logic [15:0] got;
    int          len;
    int          n;
    bit          done;

    value = raw ^ LINE_INVERT;
    done  = 1'b0;
    if (command == CMD_GAP) begin
      if (in_frame) push_status(STATUS_LENGTH);
      return;
    end
    if (!in_frame) begin
      if (value != START_BYTE) return;
      in_frame     = 1'b1;
      stored_count = 0;
    end
    if (stored_count < FRAME_BYTES) begin
      frame_mem[stored_count] = value;
      stored_count++;
    end
    if (stored_count > LENGTH_POS) begin
      len = int'(frame_mem[LENGTH_POS]);
      if (len > LENGTH_LIMIT || stored_count >= len + 1) done = 1'b1;
    end
    if (stored_count >= FRAME_BYTES) done = 1'b1;
    if (!done) return;

    n = stored_count;
    if (n <= LENGTH_POS || n > FRAME_BYTES) begin
      push_status(STATUS_LENGTH);
      return;
    end
    len = int'(frame_mem[LENGTH_POS]);
    if (n != len + 1 || len < 1) begin
      push_status(STATUS_LENGTH);
      return;
    end
    sum = 16'((257 - len) * 256 + len - 2);
    for (int k = 0; k + 1 < len; k++) sum = sum + 16'(frame_mem[k]);
    got = {frame_mem[len - 1], frame_mem[len]};
    if (sum != got) begin
      push_status(STATUS_CHECKSUM);
      return;
    end
    for (int k = 0; k < n; k++) begin
      push_result(frame_mem[k], k, STATUS_OK, (k + 1 == n));
    end
    in_frame     = 1'b0;
    stored_count = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results_q.delete();
      in_frame      = 1'b0;
      stored_count  = 0;
      error_count   = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte=%h idx=%0d status=%0d last=%b",
                                    out_i.frame_byte, out_i.byte_index, out_i.frame_status,
                                    out_i.last));
        end else begin
          oldest_result = expected_results_q.pop_front();
          if (out_i.frame_byte !== oldest_result.frame_byte)
            report_mismatch($sformatf("frame_byte %h, expected %h",
                                      out_i.frame_byte, oldest_result.frame_byte));
          if (out_i.byte_index !== oldest_result.byte_index)
            report_mismatch($sformatf("byte_index %0d, expected %0d",
                                      out_i.byte_index, oldest_result.byte_index));
          if (out_i.frame_status !== oldest_result.frame_status)
            report_mismatch($sformatf("frame_status %0d, expected %0d",
                                      out_i.frame_status, oldest_result.frame_status));
          if (out_i.last !== oldest_result.last)
            report_mismatch($sformatf("last %b, expected %b",
                                      out_i.last, oldest_result.last));
        end
      end
      if (in_i.valid && in_i.ready) predict_line_item(in_i.command, in_i.line_byte);
      error_count_o <= error_count;
      pending_o     <= expected_results_q.size();
    end
  end

endmodule

// File: tb/process_bus_telegram_receiver_test.sv
`timescale 1ns / 1ps
module process_bus_telegram_receiver_test;
  import pbtr_pkg::*;

  localparam int ITEM_TARGET    = 200;
  localparam int QUIET_START    = 160;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   sent_items;
  int   stall_cycles = 0;
  int   error_count;
  int   pending;
  logic [7:0] telegram_q[$];

  pbtr_in_if  in_if ();
  pbtr_out_if out_if ();

  process_bus_telegram_receiver u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  process_bus_telegram_receiver_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_if),
    .out_i         (out_if),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // no transaction on either side for too long means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        out_if.ready <= 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
  end

  task automatic send_txn(input logic command, input logic [7:0] raw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.command   <= command;
    in_if.line_byte <= raw;
    do @(posedge clk_i); while (!in_if.ready);
    sent_items++;
  endtask

  // decoded telegram with length byte len; fill < 0 gives random payload
  function automatic void build_telegram(int len, bit bad_sum, int fill);
    logic [15:0] sum;
    telegram_q.delete();
    telegram_q.push_back(START_BYTE);
    telegram_q.push_back(8'(len));
    for (int k = 2; k <= len - 2; k++) begin
      telegram_q.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
    sum = 16'((257 - len) * 256 + len - 2);
    for (int k = 0; k + 1 < len; k++) sum = sum + 16'(telegram_q[k]);
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    telegram_q.push_back(sum[15:8]);
    telegram_q.push_back(sum[7:0]);
  endfunction

  task automatic send_decoded(input int count);
    for (int k = 0; k < count && k < telegram_q.size(); k++) begin
      send_txn(CMD_BYTE, telegram_q[k] ^ LINE_INVERT);
    end
  endtask

  task automatic send_header(input logic [7:0] len);
    send_txn(CMD_BYTE, START_BYTE ^ LINE_INVERT);
    send_txn(CMD_BYTE, len ^ LINE_INVERT);
  endtask

  initial begin
    int pick;
    int len;
    rst_ni          = 1'b0;
    idle_on         = 1'b1;
    sent_items      = 0;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_BYTE;
    in_if.line_byte = 8'h00;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    send_txn(CMD_GAP, 8'($urandom_range(0, 255)));
    send_txn(CMD_BYTE, 8'h00);
    send_txn(CMD_BYTE, 8'hFF);
    build_telegram(3, 1'b0, -1);
    send_decoded(telegram_q.size());
    build_telegram(3, 1'b1, -1);
    send_decoded(telegram_q.size());
    send_header(8'd0);
    send_header(8'd1);
    send_header(8'd33);
    send_txn(CMD_BYTE, START_BYTE ^ LINE_INVERT);
    send_txn(CMD_GAP, 8'($urandom_range(0, 255)));
    build_telegram(4, 1'b0, START_BYTE);
    send_decoded(telegram_q.size());

    // longest telegram
    build_telegram(32, 1'b0, -1);
    send_decoded(telegram_q.size());

    // random
    while (sent_items < ITEM_TARGET) begin
      if (sent_items >= QUIET_START) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 32) : $urandom_range(3, 12);
      if (pick < 55) begin
        build_telegram(len, 1'b0, -1);
        send_decoded(telegram_q.size());
      end else if (pick < 65) begin
        build_telegram(len, 1'b1, -1);
        send_decoded(telegram_q.size());
      end else if (pick < 73) begin
        build_telegram(len, 1'b0, -1);
        send_decoded($urandom_range(1, len));
        send_txn(CMD_GAP, 8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        send_header(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) send_txn(CMD_BYTE, 8'($urandom_range(0, 255)));
        send_txn(CMD_GAP, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_txn(($urandom_range(0, 3) == 0) ? CMD_GAP : CMD_BYTE,
                   8'($urandom_range(0, 255)));
        end
        send_txn(CMD_GAP, 8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pbtr_pkg.sv
design/pbtr_if.sv
design/pbtr_ram.sv
design/pbtr_queue.sv
design/pbtr_front.sv
design/pbtr_back.sv
design/process_bus_telegram_receiver.sv
tb/process_bus_telegram_receiver_checker.sv
tb/process_bus_telegram_receiver_test.sv
